// File: src/dip_pkg.sv
// ----------------------------------------------------------------------------
// dip_pkg
// shared types, character codes and byte classes for the decimal text parser
// ----------------------------------------------------------------------------
package dip_pkg;

  localparam int unsigned ValueW = 64;

  localparam logic [7:0] CharUnder = 8'h5F;  // '_'
  localparam logic [7:0] CharZero  = 8'h30;  // '0'
  localparam logic [7:0] CharNine  = 8'h39;  // '9'
  localparam logic [7:0] CharPlus  = 8'h2B;  // '+'
  localparam logic [7:0] CharMinus = 8'h2D;  // '-'

  // one text byte as it enters the parser
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } item_t;

  // result of one field, magnitude not yet signed
  typedef struct packed {
    logic              ok;
    logic              negative;
    logic [ValueW-1:0] magnitude;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return c inside {[8'h09:8'h0D], [8'h1C:8'h20], 8'h85, 8'hA0};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CharZero:CharNine]};
  endfunction

endpackage

// File: src/dip_parse.sv
// ----------------------------------------------------------------------------
// dip_parse
// per-byte phase tracking and decimal accumulation, with a result register
// ----------------------------------------------------------------------------
module dip_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  output logic             item_ready,
  input  dip_pkg::item_t   item,
  output logic             res_valid,
  input  logic             res_ready,
  output dip_pkg::result_t res
);

  typedef enum logic [2:0] {
    PH_LEFT,
    PH_SIGN,
    PH_DIGIT,
    PH_UNDER,
    PH_RIGHT,
    PH_FAIL
  } phase_t;

  phase_t                     phase_r, phase_nxt;
  logic [dip_pkg::ValueW-1:0] acc_r, acc_nxt, acc_step;
  logic                       neg_r, neg_nxt;
  logic                       res_valid_r;
  dip_pkg::result_t           res_r;
  logic                       take;

  assign item_ready = !res_valid_r || res_ready;
  assign take       = item_valid && item_ready;
  assign res_valid  = res_valid_r;
  assign res        = res_r;

  // acc * 10 + digit as two shifts and a three-term add
  assign acc_step = {acc_r[dip_pkg::ValueW-4:0], 3'b000}
                  + {acc_r[dip_pkg::ValueW-2:0], 1'b0}
                  + {{(dip_pkg::ValueW-4){1'b0}}, item.data_byte[3:0]};

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    if (item.has_byte) begin
      case (phase_r)
        PH_LEFT, PH_SIGN, PH_DIGIT, PH_UNDER, PH_RIGHT: begin
          if (dip_pkg::is_space(item.data_byte)) begin
            if (phase_r == PH_UNDER || phase_r == PH_SIGN) phase_nxt = PH_FAIL;
            else if (phase_r == PH_DIGIT) phase_nxt = PH_RIGHT;
          end else if (item.data_byte == dip_pkg::CharPlus ||
                       item.data_byte == dip_pkg::CharMinus) begin
            if (phase_r != PH_LEFT) begin
              phase_nxt = PH_FAIL;
            end else begin
              phase_nxt = PH_SIGN;
              if (item.data_byte == dip_pkg::CharMinus) neg_nxt = 1'b1;
            end
          end else if (dip_pkg::is_digit(item.data_byte)) begin
            if (phase_r == PH_RIGHT) begin
              phase_nxt = PH_FAIL;
            end else begin
              phase_nxt = PH_DIGIT;
              acc_nxt   = acc_step;
            end
          end else if (item.data_byte == dip_pkg::CharUnder) begin
            phase_nxt = (phase_r == PH_DIGIT) ? PH_UNDER : PH_FAIL;
          end else begin
            phase_nxt = PH_FAIL;
          end
        end
        default: phase_nxt = PH_FAIL;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEFT;
      acc_r       <= '0;
      neg_r       <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (take) begin
        if (item.last) begin
          phase_r <= PH_LEFT;
          acc_r   <= '0;
          neg_r   <= 1'b0;
        end else begin
          phase_r <= phase_nxt;
          acc_r   <= acc_nxt;
          neg_r   <= neg_nxt;
        end
      end
      if (item_ready) begin
        res_valid_r     <= take && item.last;
        res_r.ok        <= (phase_nxt == PH_DIGIT) || (phase_nxt == PH_RIGHT);
        res_r.negative  <= neg_nxt;
        res_r.magnitude <= acc_nxt;
      end
    end
  end

endmodule

// File: src/dip_out_stage.sv
// ----------------------------------------------------------------------------
// dip_out_stage
// applies sign and failure zeroing, holds the result word for the sink
// ----------------------------------------------------------------------------
module dip_out_stage (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              res_valid,
  output logic                              res_ready,
  input  dip_pkg::result_t                  res,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic signed [dip_pkg::ValueW-1:0] out_value,
  output logic                              out_ok
);

  logic                              out_valid_r;
  logic signed [dip_pkg::ValueW-1:0] value_r, value_nxt;
  logic                              ok_r;

  assign res_ready  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_value  = value_r;
  assign out_ok     = ok_r;

  always_comb begin
    if (!res.ok) value_nxt = '0;
    else if (res.negative) value_nxt = $signed({dip_pkg::ValueW{1'b0}} - res.magnitude);
    else value_nxt = $signed(res.magnitude);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
      value_r     <= value_nxt;
      ok_r        <= res.ok;
    end
  end

endmodule

// File: src/decimal_integer_text_parser.sv
// ----------------------------------------------------------------------------
// decimal_integer_text_parser
// parses one text field, one byte per word, as a signed 64-bit decimal
// ----------------------------------------------------------------------------
// path: the tlast word passes the input, parse result and output registers
// throughput: one input word per cycle unless out_tready stalls, bound by the
// combinational shift-add loop that updates the accumulator and parse phase
// reset: synchronous active-low rst_n empties all stages and returns the
// parser to the leading-whitespace phase with a zero accumulator
module decimal_integer_text_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] has_byte
  input  logic        in_tlast,   // last item of the field
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] value, two's complement
  output logic        out_tuser   // [0] ok
);

  // input register stage
  logic             s0_valid_r;
  dip_pkg::item_t   s0_item_r;
  logic             s0_ready;

  // parse result register handshake
  logic             res_valid;
  logic             res_ready;
  dip_pkg::result_t res;

  logic signed [dip_pkg::ValueW-1:0] out_value;

  // input register accepts whenever it is empty or being drained
  assign in_tready = !s0_valid_r || s0_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_tready) begin
      s0_valid_r          <= in_tvalid;
      s0_item_r.data_byte <= in_tdata;
      s0_item_r.has_byte  <= in_tuser;
      s0_item_r.last      <= in_tlast;
    end
  end

  // phase tracking and accumulation, one word per cycle unless the result stalls
  dip_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (s0_valid_r),
    .item_ready (s0_ready),
    .item       (s0_item_r),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // sign application and output register
  dip_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_value  (out_value),
    .out_ok     (out_tuser)
  );

  assign out_tdata = out_value;

endmodule
